[src/go_to_goal_proportional_steer_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef GO_TO_GOAL_PROPORTIONAL_STEER_CORE_MACROS_SVH
`define GO_TO_GOAL_PROPORTIONAL_STEER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define GTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/gtg_pkg.sv]
// Shared types and constants for the go-to-goal steering core.
package gtg_pkg;
    localparam logic [1:0] KIND_GOAL = 2'd0;
    localparam logic [1:0] KIND_POSE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_POSE     = 3'd2;
    localparam logic [2:0] ST_IDLE     = 3'd3;
    localparam logic [2:0] ST_DRIVING  = 3'd4;
    localparam logic [2:0] ST_REACHED  = 3'd5;

    localparam logic [1:0] REG_DIST_GAIN = 2'd0;
    localparam logic [1:0] REG_HEAD_GAIN = 2'd1;
    localparam logic [1:0] REG_THRESH    = 2'd2;

    // angle unit 2^-16 rad
    localparam int AW = 28;
    localparam logic signed [AW-1:0] ANG_PI      = 28'sd205887;
    localparam logic signed [AW-1:0] ANG_TWO_PI  = 28'sd411775;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 28'sd102944;
    localparam logic [15:0] INV_GAIN = 16'd39797;
    // CORDIC vector width: 17-bit diff << 8, plus growth
    localparam int CW = 28;

    typedef enum logic [2:0] {
        t_IDLE_S, t_LOAD_S, t_ROT_S, t_SCALE_S, t_CMD_S, t_TURN_S, t_OUT_S
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic load;
        logic rot;
        logic scale;
        logic cmd;
        logic turn;
        logic finish;
        logic push_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } t_stat;

    function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                5'd0: r = 28'sd51472;
                5'd1: r = 28'sd30386;
                5'd2: r = 28'sd16055;
                5'd3: r = 28'sd8150;
                5'd4: r = 28'sd4091;
                5'd5: r = 28'sd2047;
                5'd6: r = 28'sd1024;
                5'd7: r = 28'sd512;
                5'd8: r = 28'sd256;
                5'd9: r = 28'sd128;
                5'd10: r = 28'sd64;
                5'd11: r = 28'sd32;
                5'd12: r = 28'sd16;
                5'd13: r = 28'sd8;
                5'd14: r = 28'sd4;
                5'd15: r = 28'sd2;
                5'd16: r = 28'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage

[src/gtg_ctrl.sv]
// Sequencer for the go-to-goal core: item intake, CORDIC loop, command math.
module gtg_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_kind,
    input  logic           i_tick_go,
    input  gtg_pkg::t_stat i_stat,
    output logic           o_ready,
    output gtg_pkg::t_cmd  o_cmd
);
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    gtg_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtg_pkg::t_IDLE_S;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            gtg_pkg::t_IDLE_S: begin
                o_ready = !i_stat.out_full;
                if (i_valid && o_ready) begin
                    o_cmd.take_in = 1'b1;
                    if (i_kind == gtg_pkg::KIND_TICK && i_tick_go) begin
                        n_state = gtg_pkg::t_LOAD_S;
                    end else begin
                        o_cmd.push_out = 1'b1;
                    end
                end
            end
            gtg_pkg::t_LOAD_S: begin
                o_cmd.load = 1'b1;
                n_step = '0;
                n_state = gtg_pkg::t_ROT_S;
            end
            gtg_pkg::t_ROT_S: begin
                o_cmd.rot = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    n_state = gtg_pkg::t_SCALE_S;
                end
            end
            gtg_pkg::t_SCALE_S: begin
                o_cmd.scale = 1'b1;
                n_state = gtg_pkg::t_CMD_S;
            end
            gtg_pkg::t_CMD_S: begin
                o_cmd.cmd = 1'b1;
                n_state = gtg_pkg::t_TURN_S;
            end
            gtg_pkg::t_TURN_S: begin
                o_cmd.turn = 1'b1;
                n_state = gtg_pkg::t_OUT_S;
            end
            gtg_pkg::t_OUT_S: begin
                o_cmd.finish = 1'b1;
                o_cmd.push_out = 1'b1;
                n_state = gtg_pkg::t_IDLE_S;
            end
            default: n_state = gtg_pkg::t_IDLE_S;
        endcase
    end
endmodule

[src/gtg_dp.sv]
// Datapath: goal FIFO, pose registers, CORDIC, gains and output register.
module gtg_dp #(
    parameter int GOAL_DEPTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gtg_pkg::t_cmd      i_cmd,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    input  logic [15:0]        i_dist_gain,
    input  logic [15:0]        i_head_gain,
    input  logic [14:0]        i_thresh,
    input  logic               i_out_ready,
    output logic               o_tick_go,
    output gtg_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [2:0]         o_status,
    output logic signed [19:0] o_linear_speed,
    output logic signed [19:0] o_turn_rate,
    output logic [4:0]         o_goals_waiting
);
    localparam int AW = gtg_pkg::AW;
    localparam int CW = gtg_pkg::CW;
    localparam int PW = (GOAL_DEPTH > 1) ? $clog2(GOAL_DEPTH) : 1;
    localparam int QW = $clog2(GOAL_DEPTH + 1);
    localparam int SUMW = QW + 1;
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    function automatic logic signed [19:0] sat20(input logic signed [49:0] v);
        if (v > 50'sd524287) return 20'sd524287;
        if (v < -50'sd524288) return -20'sd524288;
        return 20'(v);
    endfunction

    logic signed [15:0] r_mem_x [GOAL_DEPTH];
    logic signed [15:0] r_mem_y [GOAL_DEPTH];
    logic signed [15:0] r_gx, r_gy;
    logic [PW-1:0] r_head;
    logic [QW-1:0] r_count;
    logic signed [15:0] r_cx, r_cy, r_ch;
    logic r_seen;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic [SW-1:0] r_i;
    logic signed [47:0] r_prod;
    logic signed [33:0] r_dist;
    logic signed [AW-1:0] r_err;
    logic r_near;
    logic signed [19:0] r_lin;
    logic signed [47:0] r_tprod;
    logic r_out_valid;
    logic [2:0] r_status;
    logic signed [19:0] r_lin_o, r_turn_o;
    logic [4:0] r_gw;

    logic [PW-1:0] w_tail;
    logic [SUMW-1:0] w_sum;
    logic w_full;
    logic signed [16:0] w_dx, w_dy;
    logic signed [CW-1:0] w_xs, w_ys;

    assign w_full = (r_count == QW'(GOAL_DEPTH));
    // tail slot: head plus count, wrapped once by the depth
    assign w_sum = SUMW'(r_head) + SUMW'(r_count);
    always_comb begin
        if (w_sum >= SUMW'(GOAL_DEPTH))
            w_tail = PW'(w_sum - SUMW'(GOAL_DEPTH));
        else
            w_tail = PW'(w_sum);
    end
    assign o_tick_go = r_seen && (r_count != '0);
    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign w_dx = 17'(r_gx) - 17'(r_cx);
    assign w_dy = 17'(r_gy) - 17'(r_cy);
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    // goal memory write and registered head read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in && i_kind == gtg_pkg::KIND_GOAL && !w_full) begin
            r_mem_x[w_tail] <= i_goal_x;
            r_mem_y[w_tail] <= i_goal_y;
        end
        r_gx <= r_mem_x[r_head];
        r_gy <= r_mem_y[r_head];
    end

    // queue and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_ch    <= '0;
            r_seen  <= 1'b0;
        end else begin
            if (i_cmd.take_in && i_kind == gtg_pkg::KIND_GOAL && !w_full)
                r_count <= r_count + 1'b1;
            if (i_cmd.take_in && i_kind == gtg_pkg::KIND_POSE) begin
                r_cx   <= i_pose_x;
                r_cy   <= i_pose_y;
                r_ch   <= i_pose_heading;
                r_seen <= 1'b1;
            end
            if (i_cmd.finish && r_near) begin
                r_head  <= (r_head == PW'(GOAL_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
        end
    end

    // CORDIC vectoring and command arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_i <= '0;
            if (w_dx < 0) begin
                if (w_dy >= 0) begin
                    r_x <= CW'(w_dy) <<< 8;
                    r_y <= -(CW'(w_dx) <<< 8);
                    r_z <= gtg_pkg::ANG_HALF_PI;
                end else begin
                    r_x <= -(CW'(w_dy) <<< 8);
                    r_y <= CW'(w_dx) <<< 8;
                    r_z <= -gtg_pkg::ANG_HALF_PI;
                end
            end else begin
                r_x <= CW'(w_dx) <<< 8;
                r_y <= CW'(w_dy) <<< 8;
                r_z <= '0;
            end
        end
        if (i_cmd.rot) begin
            r_i <= r_i + 1'b1;
            if (r_y >= 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + gtg_pkg::atan_lut(5'(r_i));
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - gtg_pkg::atan_lut(5'(r_i));
            end
            if (r_i == SW'(CORDIC_STEPS - 1))
                r_prod <= 48'(r_x + ((r_y >= 0) ? w_ys : -w_ys))
                          * $signed({1'b0, gtg_pkg::INV_GAIN});
        end
        if (i_cmd.scale) begin
            r_dist <= 34'((r_prod >>> 16) + 48'sd128) >>> 8;
            r_err  <= r_z - (AW'(r_ch) <<< 3);
        end
        if (i_cmd.cmd) begin
            r_near <= r_dist <= $signed({19'd0, i_thresh});
            r_lin  <= sat20(50'((r_dist * $signed({1'b0, i_dist_gain}) + 51'sd2048) >>> 12));
            if (r_err > gtg_pkg::ANG_PI)       r_err <= r_err - gtg_pkg::ANG_TWO_PI;
            else if (r_err < -gtg_pkg::ANG_PI) r_err <= r_err + gtg_pkg::ANG_TWO_PI;
        end
        if (i_cmd.turn)
            r_tprod <= 48'(r_err) * $signed({1'b0, i_head_gain});
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out) begin
            r_lin_o  <= '0;
            r_turn_o <= '0;
            if (i_cmd.finish) begin
                r_status <= r_near ? gtg_pkg::ST_REACHED : gtg_pkg::ST_DRIVING;
                r_gw     <= 5'(r_count - (r_near ? QW'(1) : QW'(0)));
                if (!r_near) begin
                    r_lin_o  <= r_lin;
                    r_turn_o <= sat20(50'((r_tprod + 48'sd16384) >>> 15));
                end
            end else begin
                r_gw <= 5'(r_count);
                case (i_kind)
                    gtg_pkg::KIND_GOAL: begin
                        r_status <= w_full ? gtg_pkg::ST_REJECTED : gtg_pkg::ST_ACCEPTED;
                        r_gw     <= 5'(r_count + (w_full ? QW'(0) : QW'(1)));
                    end
                    gtg_pkg::KIND_POSE: r_status <= gtg_pkg::ST_POSE;
                    default:            r_status <= gtg_pkg::ST_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_linear_speed  = r_lin_o;
    assign o_turn_rate     = r_turn_o;
    assign o_goals_waiting = r_gw;
endmodule

[src/go_to_goal_proportional_steer_core.sv]
// Top level of the go-to-goal steering core: register port, controller, datapath.
//  channel | dir | handshake          | beat
//  input   | in  | i_valid / o_ready  | kind, goal x/y, pose x/y/heading
//  result  | out | o_valid / i_ready  | status, speeds, goals waiting
//  config  | in  | APB psel/penable   | gains, reach threshold
// Goal, pose and idle beats go from intake straight into the output register.
// A steering tick runs load, the one-step-per-cycle CORDIC loop, scale, command, turn and output.
// Synchronous active-low reset clears queue, pose flag and config to defaults.
// Input is held off while a result waits and the output register is still occupied.
module go_to_goal_proportional_steer_core #(
    parameter int GOAL_DEPTH   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [19:0] o_linear_speed,
    output logic signed [19:0] o_turn_rate,
    output logic [4:0]         o_goals_waiting,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [15:0] r_dist_gain, r_head_gain;
    logic [14:0] r_thresh;
    gtg_pkg::t_cmd  w_cmd;
    gtg_pkg::t_stat w_stat;
    logic w_tick_go;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gain <= 16'd5120;
            r_head_gain <= 16'd10240;
            r_thresh    <= 15'd512;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                gtg_pkg::REG_DIST_GAIN: r_dist_gain <= pwdata[15:0];
                gtg_pkg::REG_HEAD_GAIN: r_head_gain <= pwdata[15:0];
                gtg_pkg::REG_THRESH:    r_thresh    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gtg_pkg::REG_DIST_GAIN: prdata = {16'd0, r_dist_gain};
            gtg_pkg::REG_HEAD_GAIN: prdata = {16'd0, r_head_gain};
            gtg_pkg::REG_THRESH:    prdata = {17'd0, r_thresh};
            default:                prdata = '0;
        endcase
    end

    gtg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_kind(i_kind),
        .i_tick_go(w_tick_go), .i_stat(w_stat), .o_ready(o_ready), .o_cmd(w_cmd)
    );

    gtg_dp #(.GOAL_DEPTH(GOAL_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_kind(i_kind),
        .i_goal_x(i_goal_x), .i_goal_y(i_goal_y), .i_pose_x(i_pose_x),
        .i_pose_y(i_pose_y), .i_pose_heading(i_pose_heading),
        .i_dist_gain(r_dist_gain), .i_head_gain(r_head_gain), .i_thresh(r_thresh),
        .i_out_ready(i_ready), .o_tick_go(w_tick_go), .o_stat(w_stat),
        .o_out_valid(o_valid), .o_status(o_status), .o_linear_speed(o_linear_speed),
        .o_turn_rate(o_turn_rate), .o_goals_waiting(o_goals_waiting)
    );
endmodule

[src/gtg_checker.sv]
// Port-level checker for the go-to-goal steering core, with its bind.
`include "go_to_goal_proportional_steer_core_macros.svh"
module gtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        i_valid,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [19:0] o_linear_speed,
    input logic [19:0] o_turn_rate
);
    logic w_quiet, w_driving, w_out_wait, w_in_beat;

    assign w_quiet    = (o_linear_speed == '0) && (o_turn_rate == '0);
    assign w_driving  = (o_status == gtg_pkg::ST_DRIVING);
    assign w_out_wait = o_valid && !i_ready;
    assign w_in_beat  = i_valid && o_ready;

    // speeds are zero on every beat that is not a driving one
    `GTG_ASSERT_IMP(a_speed_zero, i_clk, i_rst_n, o_valid && !w_driving, w_quiet)
    `GTG_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= gtg_pkg::ST_REACHED)
    // a waiting result beat holds
    `GTG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_wait, o_valid && $stable(o_status))
    // an input beat either yields a result next cycle or blocks the input
    `GTG_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_in_beat, o_valid || !o_ready)
endmodule

bind go_to_goal_proportional_steer_core gtg_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .i_valid(i_valid),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_linear_speed(o_linear_speed), .o_turn_rate(o_turn_rate)
);
